>>> rtl/core/cab_pkg.sv
// ----------------------------------------------------------------------------
// cab_pkg
// shared types and constants of the clipped alpha over blend pipeline
// ----------------------------------------------------------------------------
package cab_pkg;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PLACE_X      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLACE_Y      = 2'd3;

    localparam logic [11:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [11:0] FRAME_HEIGHT_RST = 12'd480;

    localparam int Q_W = 8;
    localparam int REM_W = 24;
    localparam int DEN_W = 16;

    // reciprocal of 255 scaled by 2**23, exact for 16 bit dividends
    localparam logic [31:0] RECIP_255 = 32'h0000_8081;
    localparam int RECIP_SHIFT = 23;

    localparam int IN_DATA_W = 88;
    localparam int OUT_DATA_W = 64;

    typedef struct packed {
        logic                          we;
        logic                          copy;
        logic signed [12:0]            col;
        logic signed [12:0]            row;
        logic [31:0]                   src;
        logic [31:0]                   dst;
        logic [DEN_W-1:0]              wd;
        logic [DEN_W-1:0]              ws;
        logic [DEN_W-1:0]              den;
        logic [2:0][REM_W-1:0]         rem;
        logic [2:0][Q_W-1:0]           quo;
        logic [7:0]                    alpha;
    } cab_item_t;

endpackage

>>> rtl/core/clipped_alpha_over_blend_top.sv
// ----------------------------------------------------------------------------
// clipped_alpha_over_blend_top
// composites one texture pixel over one frame pixel with clipping
// ----------------------------------------------------------------------------
// Each input beat on s_axis carries a texture pixel, its column and row in the
// texture and the frame pixel it lands on (BGRA, straight alpha). Each beat
// gives exactly one output beat on m_axis with the write enable, the target
// column and row and the pixel to write. The user must set frame size and
// placement on the cfg write port while the block is idle; it is not enforced.
// The block takes one beat per clock unless m_tready stalls. It has 12
// register stages: three front stages (placement, clip and weights,
// numerators), eight divider stages that each settle one quotient bit of
// the three color channels, and the output register.
// Each stage holds its beat until the next one takes it, so a stall on
// m_tready fills the bubbles first and then drops s_tready; nothing is lost
// or repeated. Reset empties the pipeline and loads a 640x480 frame placed
// at the origin.
// ----------------------------------------------------------------------------
module clipped_alpha_over_blend_top #(
    parameter int MAX_DIM = 2048
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [cab_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [cab_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // src_col[10:0], src_row[21:11], src_pixel[53:22], dst_pixel[85:54]
    input  logic [cab_pkg::IN_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // write_enable[0], dst_col[13:1], dst_row[26:14], blended_pixel[58:27]
    output logic [cab_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int DIM_BITS = $clog2(MAX_DIM + 1);
    localparam int CW = (DIM_BITS > 12) ? DIM_BITS : 12;

    logic [11:0]         frame_width_reg, frame_height_reg;
    logic signed [11:0]  place_x_reg, place_y_reg;
    logic [CW-1:0]       dim_w, dim_h;

    logic                      v [0:8];
    logic                      r [0:8];
    cab_pkg::cab_item_t        it [0:8];

    logic                      out_v_reg, out_rdy;
    logic [cab_pkg::OUT_DATA_W-1:0] out_reg, out_next;
    logic [31:0]               pix;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg <= cab_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= cab_pkg::FRAME_HEIGHT_RST;
            place_x_reg <= '0;
            place_y_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                cab_pkg::REG_FRAME_WIDTH: frame_width_reg <= cfg_wr_data;
                cab_pkg::REG_FRAME_HEIGHT: frame_height_reg <= cfg_wr_data;
                cab_pkg::REG_PLACE_X: place_x_reg <= cfg_wr_data;
                cab_pkg::REG_PLACE_Y: place_y_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // oversized frames clamp to the largest supported size
    assign dim_w = (32'(frame_width_reg) > MAX_DIM) ? CW'(MAX_DIM) : CW'(frame_width_reg);
    assign dim_h = (32'(frame_height_reg) > MAX_DIM) ? CW'(MAX_DIM) : CW'(frame_height_reg);

    cab_front #(.CW(CW)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .place_x   (place_x_reg),
        .place_y   (place_y_reg),
        .dim_w     (dim_w),
        .dim_h     (dim_h),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_col    (s_tdata[10:0]),
        .in_row    (s_tdata[21:11]),
        .in_src    (s_tdata[53:22]),
        .in_dst    (s_tdata[85:54]),
        .out_valid (v[0]),
        .out_ready (r[0]),
        .out_item  (it[0])
    );

    // most significant quotient bit first
    for (genvar g = 0; g < cab_pkg::Q_W; g++) begin : g_div
        cab_div_step #(.BIT(cab_pkg::Q_W - 1 - g)) u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (v[g]),
            .in_ready  (r[g]),
            .in_item   (it[g]),
            .out_valid (v[g+1]),
            .out_ready (r[g+1]),
            .out_item  (it[g+1])
        );
    end

    assign out_rdy = !out_v_reg || m_tready;
    assign r[8] = out_rdy;

    always_comb begin
        if (!it[8].we) begin
            pix = it[8].dst;
        end else if (it[8].copy) begin
            pix = it[8].src;
        end else begin
            pix = {it[8].alpha, it[8].quo[2], it[8].quo[1], it[8].quo[0]};
        end
        out_next = {5'b0, pix, it[8].row, it[8].col, it[8].we};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (out_rdy) begin
            out_v_reg <= v[8];
        end
    end

    always_ff @(posedge aclk) begin
        if (out_rdy) out_reg <= out_next;
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata = out_reg;

    // input only backs up when every stage holds a beat and the sink stalls
    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled while pipeline has room");

    a_we_col: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (!m_tdata[13] && !m_tdata[26]))
        else $error("write enabled for a negative target");

    a_we_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[58:51] != 8'd0))
        else $error("written pixel has zero alpha");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v[8] && !r[8]) |=> v[8])
        else $error("last divider stage dropped a beat under stall");

endmodule

>>> rtl/core/cab_front.sv
// ----------------------------------------------------------------------------
// cab_front
// placement, clipping and blend weights: three register stages
// ----------------------------------------------------------------------------
module cab_front #(
    parameter int CW = 12
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic signed [11:0]   place_x,
    input  logic signed [11:0]   place_y,
    input  logic [CW-1:0]        dim_w,
    input  logic [CW-1:0]        dim_h,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [10:0]          in_col,
    input  logic [10:0]          in_row,
    input  logic [31:0]          in_src,
    input  logic [31:0]          in_dst,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cab_pkg::cab_item_t   out_item
);

    logic               a_v_reg, b_v_reg, c_v_reg;
    logic               a_rdy, b_rdy, c_rdy;
    cab_pkg::cab_item_t a_reg, b_reg, c_reg;
    cab_pkg::cab_item_t a_next, b_next, c_next;
    logic               in_frame;
    logic [7:0]         ta, ba, k;
    logic [31:0]        alpha_prod;

    assign c_rdy = !c_v_reg || out_ready;
    assign b_rdy = !b_v_reg || c_rdy;
    assign a_rdy = !a_v_reg || b_rdy;
    assign in_ready = a_rdy;

    // stage a: target position
    always_comb begin
        a_next = '0;
        a_next.col = 13'(place_x) + $signed({2'b00, in_col});
        a_next.row = 13'(place_y) + $signed({2'b00, in_row});
        a_next.src = in_src;
        a_next.dst = in_dst;
    end

    // stage b: clip test and weights
    always_comb begin
        ta = a_reg.src[31:24];
        ba = a_reg.dst[31:24];
        k = 8'd255 - ta;
        in_frame = !a_reg.col[12] && !a_reg.row[12]
            && (32'(a_reg.col[11:0]) < 32'(dim_w))
            && (32'(a_reg.row[11:0]) < 32'(dim_h));
        b_next = a_reg;
        b_next.we = in_frame && (ta != 8'd0);
        b_next.copy = (ta == 8'd255);
        b_next.wd = 16'(ba) * 16'(k);
        b_next.ws = {ta, 8'b0} - 16'(ta);
    end

    // stage c: numerators, divisor and alpha
    always_comb begin
        c_next = b_reg;
        c_next.den = b_reg.ws + b_reg.wd;
        for (int i = 0; i < 3; i++) begin
            c_next.rem[i] = 24'(b_reg.wd) * 24'(b_reg.dst[8*i +: 8])
                + 24'(b_reg.ws) * 24'(b_reg.src[8*i +: 8]);
        end
        c_next.quo = '0;
        alpha_prod = 32'(b_reg.ws + b_reg.wd) * cab_pkg::RECIP_255;
        c_next.alpha = alpha_prod[cab_pkg::RECIP_SHIFT +: 8];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
        end else begin
            if (a_rdy) a_v_reg <= in_valid;
            if (b_rdy) b_v_reg <= a_v_reg;
            if (c_rdy) c_v_reg <= b_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_rdy) a_reg <= a_next;
        if (b_rdy) b_reg <= b_next;
        if (c_rdy) c_reg <= c_next;
    end

    assign out_valid = c_v_reg;
    assign out_item = c_reg;

endmodule

>>> rtl/core/cab_div_step.sv
// ----------------------------------------------------------------------------
// cab_div_step
// one restoring division stage: one quotient bit for each color channel
// ----------------------------------------------------------------------------
module cab_div_step #(
    parameter int BIT = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cab_pkg::cab_item_t   in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cab_pkg::cab_item_t   out_item
);

    logic                                v_reg;
    cab_pkg::cab_item_t                  item_reg, item_next;
    logic [cab_pkg::REM_W-1:0]           den_sh;

    assign in_ready = !v_reg || out_ready;
    assign den_sh = cab_pkg::REM_W'(in_item.den) << BIT;

    always_comb begin
        item_next = in_item;
        for (int i = 0; i < 3; i++) begin
            if (in_item.rem[i] >= den_sh) begin
                item_next.rem[i] = in_item.rem[i] - den_sh;
                item_next.quo[i][BIT] = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= 1'b0;
        end else if (in_ready) begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) item_reg <= item_next;
    end

    assign out_valid = v_reg;
    assign out_item = item_reg;

endmodule
